FILE: hdl/mthfc_pkg.sv
package mthfc_pkg;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] TICK_MAX      = 16'hFFFF;

  // Frame byte positions, counted from zero.
  localparam logic [2:0] TEMP_HI_IDX    = 3'd3;
  localparam logic [2:0] TEMP_LO_IDX    = 3'd4;
  localparam logic [2:0] HUMI_HI_IDX    = 3'd5;
  localparam logic [2:0] HUMI_LO_IDX    = 3'd6;
  localparam logic [2:0] CRC_START_IDX  = 3'd2;
  localparam logic [2:0] LAST_MIN_IDX   = 3'd6;
  localparam logic [2:0] BYTE_COUNT_MAX = 3'd7;

  localparam logic signed [12:0] TEMP_MIN = -13'sd40;
  localparam logic signed [12:0] TEMP_MAX = 13'sd80;
  localparam logic signed [12:0] HUMI_MIN = 13'sd0;
  localparam logic signed [12:0] HUMI_MAX = 13'sd100;

  // Reciprocal of ten scaled by 2^19; exact for every 16-bit magnitude.
  localparam logic [31:0] RECIP_TEN = 32'd52429;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_RANGE   = 2'd2,
    STATUS_TIMEOUT = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] temp_raw;
    logic [15:0] humi_raw;
  } frame_res_t;

  typedef struct packed {
    logic signed [12:0] whole;
    logic signed [4:0]  tenth;
  } split_t;

  // One byte through the reflected CRC-16, eight bit steps.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Signed tenths into whole part and tenths digit, both truncated toward zero.
  function automatic split_t split_tenths(input logic [15:0] raw);
    logic        neg;
    logic [15:0] mag;
    logic [31:0] prod;
    logic [12:0] q;
    logic [15:0] q10;
    logic [15:0] r;
    split_t      s;
    neg  = raw[15];
    mag  = neg ? 16'(~raw + 16'd1) : raw;
    prod = {16'h0000, mag} * RECIP_TEN;
    q    = prod[RECIP_SHIFT +: 13];
    q10  = {q[12:0], 3'b000} + {2'b00, q[12:0], 1'b0};
    r    = mag - q10;
    s.whole = neg ? -$signed(q) : $signed(q);
    s.tenth = neg ? -$signed({1'b0, r[3:0]}) : $signed({1'b0, r[3:0]});
    return s;
  endfunction

endpackage

FILE: hdl/mthfc_if.sv
interface mthfc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output op, output rx_byte, output last_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, input last_byte, output ready);
endinterface

interface mthfc_result_if;
  logic                    valid;
  logic                    ready;
  mthfc_pkg::status_t      status;
  logic signed [12:0]      temp_whole;
  logic signed [4:0]       temp_tenth;
  logic signed [12:0]      humi_whole;
  logic signed [4:0]       humi_tenth;

  modport source (output valid, output status, output temp_whole, output temp_tenth,
                  output humi_whole, output humi_tenth, input ready);
  modport sink   (input valid, input status, input temp_whole, input temp_tenth,
                  input humi_whole, input humi_tenth, output ready);
endinterface

interface mthfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/mthfc_frame.sv
module mthfc_frame (
  input  logic                  clk,
  input  logic                  rst,
  mthfc_cfg_if.sink             cfg,
  input  logic                  s1_valid,
  input  mthfc_pkg::item_t      s1_item,
  output logic                  s1_ready,
  output logic                  res_valid,
  output mthfc_pkg::frame_res_t res,
  input  logic                  res_ready
);

  logic        busy, busy_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic [15:0] held_bytes, held_bytes_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [15:0] temp_raw, temp_raw_next;
  logic [15:0] humi_raw, humi_raw_next;
  logic [15:0] tick_count, tick_count_next;
  logic [15:0] timeout_ticks;

  logic                  fire;
  logic                  has_res;
  mthfc_pkg::frame_res_t res_next;
  logic [15:0]           check;

  assign cfg.ready = 1'b1;
  assign s1_ready  = !res_valid || res_ready;
  assign fire      = s1_valid && s1_ready;
  assign check     = {s1_item.rx_byte, held_bytes[7:0]};

  always_comb begin
    busy_next       = busy;
    crc_acc_next    = crc_acc;
    held_bytes_next = held_bytes;
    byte_count_next = byte_count;
    temp_raw_next   = temp_raw;
    humi_raw_next   = humi_raw;
    tick_count_next = tick_count;
    has_res         = 1'b0;
    res_next        = '{status: mthfc_pkg::STATUS_OK, temp_raw: 16'h0000, humi_raw: 16'h0000};

    if (s1_item.op == mthfc_pkg::OP_START) begin
      busy_next       = 1'b1;
      crc_acc_next    = mthfc_pkg::CRC_INIT;
      held_bytes_next = 16'h0000;
      byte_count_next = 3'd0;
      temp_raw_next   = 16'h0000;
      humi_raw_next   = 16'h0000;
      tick_count_next = 16'h0000;
    end else if (busy && s1_item.op == mthfc_pkg::OP_TICK) begin
      if (tick_count != mthfc_pkg::TICK_MAX) begin
        tick_count_next = tick_count + 16'd1;
      end
      if (tick_count_next >= timeout_ticks) begin
        busy_next       = 1'b0;
        has_res         = 1'b1;
        res_next.status = mthfc_pkg::STATUS_TIMEOUT;
      end
    end else if (busy && s1_item.op == mthfc_pkg::OP_BYTE) begin
      // The oldest held byte leaves the hold line and enters the CRC.
      if (byte_count >= mthfc_pkg::CRC_START_IDX) begin
        crc_acc_next = mthfc_pkg::crc_fold(crc_acc, held_bytes[15:8]);
      end
      if (byte_count == mthfc_pkg::TEMP_HI_IDX || byte_count == mthfc_pkg::TEMP_LO_IDX) begin
        temp_raw_next = {temp_raw[7:0], s1_item.rx_byte};
      end
      if (byte_count == mthfc_pkg::HUMI_HI_IDX || byte_count == mthfc_pkg::HUMI_LO_IDX) begin
        humi_raw_next = {humi_raw[7:0], s1_item.rx_byte};
      end
      if (s1_item.last_byte) begin
        busy_next = 1'b0;
        has_res   = 1'b1;
        if (byte_count < mthfc_pkg::LAST_MIN_IDX || check != crc_acc_next) begin
          res_next.status = mthfc_pkg::STATUS_CRC_ERR;
        end else begin
          res_next.temp_raw = temp_raw_next;
          res_next.humi_raw = humi_raw_next;
        end
      end else begin
        held_bytes_next = {held_bytes[7:0], s1_item.rx_byte};
        if (byte_count != mthfc_pkg::BYTE_COUNT_MAX) begin
          byte_count_next = byte_count + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      crc_acc       <= mthfc_pkg::CRC_INIT;
      held_bytes    <= 16'h0000;
      byte_count    <= 3'd0;
      temp_raw      <= 16'h0000;
      humi_raw      <= 16'h0000;
      tick_count    <= 16'h0000;
      timeout_ticks <= mthfc_pkg::TIMEOUT_RESET;
      res_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        timeout_ticks <= cfg.data;
      end
      if (fire) begin
        busy       <= busy_next;
        crc_acc    <= crc_acc_next;
        held_bytes <= held_bytes_next;
        byte_count <= byte_count_next;
        temp_raw   <= temp_raw_next;
        humi_raw   <= humi_raw_next;
        tick_count <= tick_count_next;
      end
      if (s1_ready) begin
        res_valid <= fire && has_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

endmodule

FILE: hdl/mthfc_split.sv
module mthfc_split (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_valid,
  input  mthfc_pkg::frame_res_t res,
  output logic                  res_ready,
  mthfc_result_if.source        result
);

  mthfc_pkg::split_t  temp_s, humi_s;
  mthfc_pkg::status_t status_next;

  assign res_ready = !result.valid || result.ready;
  assign temp_s    = mthfc_pkg::split_tenths(res.temp_raw);
  assign humi_s    = mthfc_pkg::split_tenths(res.humi_raw);

  always_comb begin
    status_next = res.status;
    if (res.status == mthfc_pkg::STATUS_OK) begin
      if (temp_s.whole < mthfc_pkg::TEMP_MIN || temp_s.whole > mthfc_pkg::TEMP_MAX ||
          humi_s.whole < mthfc_pkg::HUMI_MIN || humi_s.whole > mthfc_pkg::HUMI_MAX) begin
        status_next = mthfc_pkg::STATUS_RANGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_ready) begin
      result.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      result.status     <= status_next;
      result.temp_whole <= temp_s.whole;
      result.temp_tenth <= temp_s.tenth;
      result.humi_whole <= humi_s.whole;
      result.humi_tenth <= humi_s.tenth;
    end
  end

endmodule

FILE: hdl/modbus_temp_humi_frame_checker_top.sv
// Checks a Modbus RTU response frame from a temperature and humidity sensor.
// The item channel carries op (start, received byte or time tick), rx_byte and
// last_byte. A start item arms the checker; the bytes of the response follow,
// the final one flagged with last_byte. Ticks count toward the timeout set by
// the cfg channel, which writes the timeout in ticks and is always ready.
// The result channel carries one item per finished frame or timeout: the
// status and the temperature and humidity split into whole part and tenths.
// An item is taken every cycle while the pipeline moves. It passes through
// an input register, then the frame stage (CRC fold, hold line, capture and
// status), then the split stage (divide by ten, range check) that loads the
// result register. The one-byte CRC update in the frame stage sets the cycle
// time. Reset returns the checker to idle with a timeout of 1000 ticks.
// When the receiver stalls, each stage holds its item and a stage takes a new
// one only once it is empty or drains, so up to three items wait inside
// before ready drops on the item channel.
module modbus_temp_humi_frame_checker_top (
  input  logic           clk,
  input  logic           rst,
  mthfc_item_if.sink     item,
  mthfc_result_if.source result,
  mthfc_cfg_if.sink      cfg
);

  // Input register stage.
  logic             s1_valid;
  logic             s1_ready;
  mthfc_pkg::item_t s1_item;

  // Frame stage result toward the split stage.
  logic                  res_valid;
  logic                  res_ready;
  mthfc_pkg::frame_res_t res;

  logic s0_ready;

  assign s0_ready   = !s1_valid || s1_ready;
  assign item.ready = s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s0_ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && item.valid) begin
      s1_item <= '{op: item.op, rx_byte: item.rx_byte, last_byte: item.last_byte};
    end
  end

  // Frame state: hold line, CRC, value capture and timeout.
  mthfc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_ready  (s1_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Split into whole and tenths, range check, result register.
  mthfc_split u_split (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .result    (result)
  );

endmodule
